// File: rtl/core/jcs_pkg.sv
`timescale 1ns / 1ps

package jcs_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int PCT_BITS    = 7;
  localparam int PROD_BITS   = SAMPLE_BITS + PCT_BITS;
  localparam int QUOT_STEPS  = PCT_BITS;

  localparam logic [SAMPLE_BITS-1:0] MIN_RESET       = SAMPLE_BITS'(500);
  localparam logic [PCT_BITS-1:0]    FULL_SCALE      = PCT_BITS'(100);
  localparam logic [7:0]             THROTTLE_OFFSET = 8'd129;

  localparam logic [1:0] PH_CAL      = 2'd0;
  localparam logic [1:0] PH_UPDATE   = 2'd1;
  localparam logic [1:0] PH_THROTTLE = 2'd2;
  localparam logic [1:0] PH_STEER    = 2'd3;

  localparam logic AX_HORIZ = 1'b0;
  localparam logic AX_VERT  = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] vert_sample;
    logic [SAMPLE_BITS-1:0] horiz_sample;
    logic                   button;
    logic                   tx_ready;
  } jcs_in_t;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic [1:0]          phase;
    logic [PCT_BITS-1:0] vert_percent_out;
    logic [PCT_BITS-1:0] horiz_percent_out;
  } jcs_out_t;

endpackage

// File: rtl/core/joystick_calibrate_and_scale.sv
`timescale 1ns / 1ps

// Joystick calibration and percent scaling. Every input beat is one tick and
// yields exactly one output beat. Calibrate and send ticks pass from acceptance
// through the done state to the output register; an update tick takes longer, as
// both axes go in turn through one seven-step restoring divider (per axis a load
// state forms (sample-min)*100, a start state starts the divider and a divide
// state waits until its quotient returns). An axis with an empty span or a sample
// at or beyond an end of its span skips the divider. A new beat is taken only when
// the previous tick is done; its result may still wait in the output register.
module joystick_calibrate_and_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jcs_pkg::jcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jcs_pkg::jcs_out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                           state_r;
  logic [1:0]                       phase_r;
  logic [1:0]                       phase_nxt;
  logic                             axis_r;
  jcs_pkg::jcs_in_t                 samp_r;
  logic [jcs_pkg::SAMPLE_BITS-1:0]  vert_max_r, vert_min_r, horiz_max_r, horiz_min_r;
  logic [jcs_pkg::PCT_BITS-1:0]     vert_pct_r, horiz_pct_r;
  logic                             tx_valid_r;
  logic [7:0]                       tx_byte_r;
  logic [jcs_pkg::PROD_BITS-1:0]    prod_r;
  logic [jcs_pkg::SAMPLE_BITS-1:0]  span_r;
  logic                             out_valid_r;
  jcs_pkg::jcs_out_t                out_r;

  logic                             in_acc;
  logic                             out_free;
  logic [jcs_pkg::SAMPLE_BITS-1:0]  sel_s, sel_lo, sel_hi;
  logic                             empty_span, over_top;
  logic [jcs_pkg::PROD_BITS-1:0]    prod;
  logic                             div_start;
  logic                             div_done;
  logic [jcs_pkg::PCT_BITS-1:0]     div_quot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = (state_r == S_START);

  always_comb begin
    unique case (phase_r)
      jcs_pkg::PH_CAL:      phase_nxt = in_data.button ? jcs_pkg::PH_UPDATE : jcs_pkg::PH_CAL;
      jcs_pkg::PH_UPDATE:   phase_nxt = jcs_pkg::PH_THROTTLE;
      jcs_pkg::PH_THROTTLE: phase_nxt = jcs_pkg::PH_STEER;
      jcs_pkg::PH_STEER:    phase_nxt = jcs_pkg::PH_UPDATE;
    endcase
  end

  always_comb begin
    if (axis_r == jcs_pkg::AX_VERT) begin
      sel_s  = samp_r.vert_sample;
      sel_lo = vert_min_r;
      sel_hi = vert_max_r;
    end else begin
      sel_s  = samp_r.horiz_sample;
      sel_lo = horiz_min_r;
      sel_hi = horiz_max_r;
    end
  end

  // A sample at or above max saturates; only the strictly inside case divides,
  // which keeps the quotient below 100.
  assign empty_span = (sel_hi <= sel_lo) || (sel_s <= sel_lo);
  assign over_top   = (sel_s >= sel_hi);
  assign prod = jcs_pkg::PROD_BITS'(sel_s - sel_lo) * jcs_pkg::PROD_BITS'(jcs_pkg::FULL_SCALE);

  jcs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= jcs_pkg::PH_CAL;
      axis_r      <= jcs_pkg::AX_HORIZ;
      vert_max_r  <= '0;
      horiz_max_r <= '0;
      vert_min_r  <= jcs_pkg::MIN_RESET;
      horiz_min_r <= jcs_pkg::MIN_RESET;
      vert_pct_r  <= '0;
      horiz_pct_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            phase_r <= phase_nxt;
            if (phase_nxt == jcs_pkg::PH_UPDATE) begin
              axis_r  <= jcs_pkg::AX_HORIZ;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_DONE;
              if (phase_nxt == jcs_pkg::PH_CAL) begin
                if (in_data.vert_sample > vert_max_r) vert_max_r <= in_data.vert_sample;
                if (in_data.horiz_sample > horiz_max_r) horiz_max_r <= in_data.horiz_sample;
                if (in_data.vert_sample < vert_min_r) vert_min_r <= in_data.vert_sample;
                if (in_data.horiz_sample < horiz_min_r) horiz_min_r <= in_data.horiz_sample;
              end
            end
          end
        end
        S_LOAD: begin
          if (empty_span || over_top) begin
            if (axis_r == jcs_pkg::AX_VERT) begin
              vert_pct_r <= empty_span ? '0 : jcs_pkg::FULL_SCALE;
              state_r    <= S_DONE;
            end else begin
              horiz_pct_r <= empty_span ? '0 : jcs_pkg::FULL_SCALE;
              axis_r      <= jcs_pkg::AX_VERT;
            end
          end else begin
            state_r <= S_START;
          end
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (axis_r == jcs_pkg::AX_VERT) begin
              vert_pct_r <= div_quot;
              state_r    <= S_DONE;
            end else begin
              horiz_pct_r <= div_quot;
              axis_r      <= jcs_pkg::AX_VERT;
              state_r     <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= in_data;
      if (phase_nxt == jcs_pkg::PH_THROTTLE && in_data.tx_ready) begin
        tx_valid_r <= 1'b1;
        tx_byte_r  <= {1'b0, vert_pct_r} + jcs_pkg::THROTTLE_OFFSET;
      end else if (phase_nxt == jcs_pkg::PH_STEER && in_data.tx_ready) begin
        tx_valid_r <= 1'b1;
        tx_byte_r  <= {1'b0, horiz_pct_r};
      end else begin
        tx_valid_r <= 1'b0;
        tx_byte_r  <= '0;
      end
    end
    if (state_r == S_LOAD) begin
      prod_r <= prod;
      span_r <= sel_hi - sel_lo;
    end
    if (state_r == S_DONE && out_free) begin
      out_r.tx_valid          <= tx_valid_r;
      out_r.tx_byte           <= tx_byte_r;
      out_r.phase             <= phase_r;
      out_r.vert_percent_out  <= vert_pct_r;
      out_r.horiz_percent_out <= horiz_pct_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_quot < jcs_pkg::FULL_SCALE)
    else $error("divider quotient reached full scale");

  a_cal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.phase == jcs_pkg::PH_CAL || out_r.phase == jcs_pkg::PH_UPDATE))
      |-> !out_r.tx_valid)
    else $error("byte sent outside a send phase");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.vert_percent_out <= jcs_pkg::FULL_SCALE &&
                     out_r.horiz_percent_out <= jcs_pkg::FULL_SCALE))
    else $error("stored percent above full scale");

endmodule

// File: rtl/core/jcs_divider.sv
`timescale 1ns / 1ps

module jcs_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [jcs_pkg::PROD_BITS-1:0]       num,
  input  logic [jcs_pkg::SAMPLE_BITS-1:0]     den,
  output logic                                done,
  output logic [jcs_pkg::PCT_BITS-1:0]        quot
);

  localparam int CNT_BITS = $clog2(jcs_pkg::QUOT_STEPS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(jcs_pkg::QUOT_STEPS - 1);

  logic [jcs_pkg::SAMPLE_BITS-1:0] rem_r;
  logic [jcs_pkg::SAMPLE_BITS-1:0] den_r;
  logic [jcs_pkg::PCT_BITS-1:0]    low_r;
  logic [jcs_pkg::PCT_BITS-1:0]    quot_r;
  logic [CNT_BITS-1:0]             cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [jcs_pkg::SAMPLE_BITS+1:0] trial;
  logic                            fits;

  // The caller guarantees num < 2**PCT_BITS * den, so the top part of num
  // already sits below den and only PCT_BITS quotient bits remain.
  assign trial = {1'b0, rem_r, low_r[jcs_pkg::PCT_BITS-1]} - {2'b00, den_r};
  assign fits  = !trial[jcs_pkg::SAMPLE_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[jcs_pkg::PROD_BITS-1:jcs_pkg::PCT_BITS];
      low_r <= num[jcs_pkg::PCT_BITS-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= fits ? trial[jcs_pkg::SAMPLE_BITS-1:0]
                     : {rem_r[jcs_pkg::SAMPLE_BITS-2:0], low_r[jcs_pkg::PCT_BITS-1]};
      low_r  <= {low_r[jcs_pkg::PCT_BITS-2:0], 1'b0};
      quot_r <= {quot_r[jcs_pkg::PCT_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
